@@ design/cls_pkg.sv @@
// cls_pkg: shared constants and types for the compacting list store.
// Used by cls_ctrl, cls_dp and compacting_list_store_top. No dependencies.
package cls_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int CMD_W    = 2;
	localparam int POS_W    = 4;
	localparam int HANDLE_W = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int CAP_W    = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic                append_en;
		logic                remove_en;
		logic                read_en;
		logic                load_en;
		logic [STATUS_W-1:0] status;
	} cls_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pos_valid;
		logic full;
		logic handle_null;
	} cls_stat_t;

endpackage

@@ design/cls_ctrl.sv @@
// cls_ctrl: command decode and result strobe for the compacting list store.
// Depends on cls_pkg; drives cls_dp through cls_cmd_t.
module cls_ctrl
	import cls_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CMD_W-1:0] command,
	input  cls_stat_t        stat,
	output cls_cmd_t         cmd,
	output logic             busy,
	output logic             done
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic state_q;
	logic accept;

	// every command completes in the accepting cycle
	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		cmd           = '0;
		cmd.load_en   = accept;
		cmd.status    = ST_INVALID;
		if (accept) begin
			unique case (command)
				CMD_APPEND: begin
					if (stat.handle_null) begin
						cmd.status = ST_INVALID;
					end else if (stat.full) begin
						cmd.status = ST_FULL;
					end else begin
						cmd.status    = ST_OK;
						cmd.append_en = 1'b1;
					end
				end
				CMD_REMOVE: begin
					if (stat.pos_valid) begin
						cmd.status    = ST_OK;
						cmd.remove_en = 1'b1;
						cmd.read_en   = 1'b1;
					end
				end
				CMD_PEEK: begin
					if (stat.pos_valid) begin
						cmd.status  = ST_OK;
						cmd.read_en = 1'b1;
					end
				end
				default: begin
					cmd.status = ST_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= accept ? ST_RESP : ST_IDLE;
		end
	end

	assign done = (state_q == ST_RESP);

endmodule

@@ design/cls_dp.sv @@
// cls_dp: slot registers, entry count, capacity register and result registers.
// Depends on cls_pkg; controlled by cls_ctrl through cls_cmd_t.
module cls_dp
	import cls_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CAP_W-1:0]    cfg_wdata,
	input  logic [POS_W-1:0]    slot_index,
	input  logic [HANDLE_W-1:0] handle_in,
	input  cls_cmd_t            cmd,
	output cls_stat_t           stat,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [COUNT_W-1:0]  count
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int AW   = $clog2(DEPTH);
	localparam int PW   = (CW > POS_W) ? CW : POS_W;
	localparam int FW   = (CW > CAP_W) ? CW : CAP_W;
	localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

	logic [HANDLE_W-1:0] slots_q [DEPTH];
	logic [CW-1:0]       count_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       count_nxt;
	logic [PW-1:0]       pos_p;
	logic [PW-1:0]       count_p;
	logic [FW-1:0]       count_f;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [STATUS_W-1:0] status_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [COUNT_W-1:0]  count_out_q;

	assign pos_p   = PW'(slot_index);
	assign count_p = PW'(count_q);
	assign count_f = FW'(count_q);
	// pos < count <= DEPTH whenever the address is used, so the dropped bits are zero
	assign rd_addr = pos_p[AW-1:0];
	assign wr_addr = count_p[AW-1:0];

	assign stat.pos_valid   = pos_p < count_p;
	// full against min(capacity, DEPTH)
	assign stat.full        = (count_f >= FW'(cap_q)) || (count_f >= DEPTH_F);
	assign stat.handle_null = (handle_in == '0);

	always_comb begin
		count_nxt = count_q;
		if (cmd.append_en) begin
			count_nxt = count_q + CW'(1);
		end else if (cmd.remove_en) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			count_q <= count_nxt;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// each slot takes the appended handle, its upper neighbor on a remove, or holds
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		localparam int NXT = (i + 1 < DEPTH) ? i + 1 : i;
		logic shift_in;
		assign shift_in = cmd.remove_en && (PW'(i) >= pos_p) && (PW'(i + 1) < count_p);
		always_ff @(posedge clk) begin
			if (cmd.append_en && (wr_addr == AW'(i))) begin
				slots_q[i] <= handle_in;
			end else if (shift_in) begin
				slots_q[i] <= slots_q[NXT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			status_q    <= cmd.status;
			handle_q    <= cmd.read_en ? slots_q[rd_addr] : '0;
			count_out_q <= COUNT_W'(count_nxt);
		end
	end

	assign status     = status_q;
	assign handle_out = handle_q;
	assign count      = count_out_q;

endmodule

@@ design/compacting_list_store_top.sv @@
// compacting_list_store_top: top level of the compacting list store.
// Depends on cls_pkg, cls_ctrl and cls_dp.

// A bounded ordered list of nonzero 32-bit handles kept densely in slots
// 0..count-1. Pulse start with command, slot_index and handle_in; busy is
// always low, so a command is taken on every clock that start is high and
// each one completes as it is taken: the slot registers, count and result are
// updated at the accepting edge (compaction is a per-slot select of self or
// upper neighbor). The result beat (status, handle_out, count) is shown in
// the cycle after acceptance with done high; it cannot be held off, so
// capture it then. Commands: append (null handle -> invalid, no room -> full),
// remove at position (returns the handle and closes the gap), peek at
// position; a position at or past count or an unused code reports invalid.
// handle_out is zero unless a remove or peek succeeds. capacity (cfg_we /
// cfg_wdata, reset 16) limits appends to min(capacity, DEPTH) entries; write
// it only while no command is in flight. Reset empties the list.
module compacting_list_store_top
	import cls_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CAP_W-1:0]    cfg_wdata,
	input  logic                start,
	input  logic [CMD_W-1:0]    command,
	input  logic [POS_W-1:0]    slot_index,
	input  logic [HANDLE_W-1:0] handle_in,
	output logic                busy,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [HANDLE_W-1:0] handle_out,
	output logic [COUNT_W-1:0]  count
);

	cls_cmd_t  cmd;
	cls_stat_t stat;

	cls_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	cls_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.slot_index (slot_index),
		.handle_in  (handle_in),
		.cmd        (cmd),
		.stat       (stat),
		.status     (status),
		.handle_out (handle_out),
		.count      (count)
	);

	// every accepted command gives a result beat in the next cycle
	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("no result beat after an accepted command");

	// failed commands never return a handle (appends return zero too, unchecked here)
	a_fail_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> handle_out == '0)
		else $error("handle returned on a failed command");

	// a null append taken while done is high is rejected and leaves the count alone
	a_null_append: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == CMD_APPEND) && (handle_in == '0) && done
		|=> done && (status == ST_INVALID) && $stable(count))
		else $error("null append not rejected");

	// a peek taken while done is high does not change the count, whether or not it succeeds
	a_peek_stable: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (command == CMD_PEEK) && done
		|=> $stable(count))
		else $error("peek changed the count");

endmodule
